// File: rtl/pngse_pkg.sv
`timescale 1ns / 1ps
// pngse_pkg: shared types, constants and byte helpers of the png stored-image encoder
// used by the accumulator unit and the top level; no dependencies
package pngse_pkg;

    localparam int MAX_SIDE   = 4096;
    localparam int SIDE_W     = 13;
    localparam int POS_W      = 12;
    localparam int RAW_W      = 26;
    localparam int RUN_MAX    = 52;
    localparam int CNT_W      = 6;

    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_SEED  = 32'hFFFFFFFF;
    localparam logic [15:0] ADLER_MOD = 16'd65521;
    localparam logic [15:0] BLOCK_MAX = 16'hFFFF;

    localparam logic [31:0] TAG_IHDR = 32'h49484452;
    localparam logic [31:0] TAG_IDAT = 32'h49444154;
    localparam logic [31:0] TAG_IEND = 32'h49454E44;
    localparam logic [7:0]  ZLIB_CMF = 8'h78;
    localparam logic [7:0]  ZLIB_FLG = 8'h01;

    // configuration register indexes
    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    // running checksums carried from beat to beat
    typedef struct packed {
        logic [31:0] crc;
        logic [15:0] adl_lo;
        logic [15:0] adl_hi;
    } t_acc;

    // reflected crc-32 over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    // big-endian byte of a word
    function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] i);
        logic [7:0] r;
        case (i)
            2'd0:    r = v[31:24];
            2'd1:    r = v[23:16];
            2'd2:    r = v[15:8];
            default: r = v[7:0];
        endcase
        return r;
    endfunction

    // png file signature
    function automatic logic [7:0] sig_byte(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0:    r = 8'd137;
            3'd1:    r = 8'h50;
            3'd2:    r = 8'h4E;
            3'd3:    r = 8'h47;
            3'd4:    r = 8'd13;
            3'd5:    r = 8'd10;
            3'd6:    r = 8'd26;
            default: r = 8'd10;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/pngse_pix_if.sv
`timescale 1ns / 1ps
// pngse_pix_if: pixel channel, one rgb pixel per beat
// no dependencies
interface pngse_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

// File: rtl/pngse_byte_if.sv
`timescale 1ns / 1ps
// pngse_byte_if: file byte channel, one byte of the png file per beat
// no dependencies
interface pngse_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_file;

    modport source (output valid, out_byte, last_of_run, end_of_file, input ready);
    modport sink   (input valid, out_byte, last_of_run, end_of_file, output ready);
endinterface

// File: rtl/pngse_acc.sv
`timescale 1ns / 1ps
// pngse_acc: shared checksum unit, folds one byte into crc-32 and adler-32
// depends on pngse_pkg
module pngse_acc (
    input  logic              i_crc_en,
    input  logic              i_raw_en,
    input  logic [7:0]        i_byte,
    input  pngse_pkg::t_acc   i_acc,
    output pngse_pkg::t_acc   o_acc
);
    logic [16:0] lo_sum;
    logic [15:0] lo_mod;
    logic [16:0] hi_sum;
    logic [15:0] hi_mod;

    // adler halves, one conditional subtract each
    always_comb begin
        lo_sum = {1'b0, i_acc.adl_lo} + {9'd0, i_byte};
        lo_mod = (lo_sum >= {1'b0, pngse_pkg::ADLER_MOD})
               ? 16'(lo_sum - {1'b0, pngse_pkg::ADLER_MOD}) : lo_sum[15:0];
        hi_sum = {1'b0, i_acc.adl_hi} + {1'b0, lo_mod};
        hi_mod = (hi_sum >= {1'b0, pngse_pkg::ADLER_MOD})
               ? 16'(hi_sum - {1'b0, pngse_pkg::ADLER_MOD}) : hi_sum[15:0];
    end

    always_comb begin
        o_acc = i_acc;
        if (i_crc_en) begin
            o_acc.crc = pngse_pkg::crc_byte(i_acc.crc, i_byte);
        end
        if (i_raw_en) begin
            o_acc.adl_lo = lo_mod;
            o_acc.adl_hi = hi_mod;
        end
    end
endmodule

// File: rtl/png_stored_image_encoder_unit.sv
`timescale 1ns / 1ps
// png_stored_image_encoder_unit: top level, byte sequencer of the png file
// depends on pngse_pkg, pngse_pix_if, pngse_byte_if, pngse_acc
//
//  channel   dir  beat                              handshake
//  i_pix     in   red, green, blue                  valid/ready
//  o_res     out  out_byte, last_of_run, end_of_file valid/ready
//  i_cfg_*   in   register index, 13-bit data       write enable only
//
// one file byte per cycle while the output is not stalled, through a single crc/adler
// unit; each accepted pixel sends 3 or 4 bytes, plus 5 at a stored-block start,
// 43 for the file header on the first pixel and 20 for the trailer on the last one.
// a run stops after 52 bytes; the rest goes out on the next accepted pixel.
// synchronous reset; any config write drops the file in progress.
// output stalls hold the sequencer; no pixel is taken while a run is in work.
module png_stored_image_encoder_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    pngse_pix_if.sink                i_pix,
    pngse_byte_if.source             o_res,
    input  logic                     i_cfg_we,
    input  logic [0:0]               i_cfg_idx,
    input  logic [12:0]              i_cfg_data
);
    typedef enum logic [4:0] {
        P_IDLE, P_HOLD, P_SIG, P_IHLEN, P_IHTAG, P_IHW, P_IHH, P_IHMISC, P_IHCRC,
        P_ZLEN, P_IDTAG, P_ZHDR, P_BHDR, P_RAW, P_ADL, P_IDCRC, P_IELEN, P_IETAG,
        P_IECRC
    } t_phase;

    t_phase r_phase, r_resume;
    logic [2:0]  r_idx;
    logic [1:0]  r_ridx;
    logic [pngse_pkg::CNT_W-1:0] r_cnt;
    logic [12:0] r_width, r_height;
    logic [7:0]  r_red, r_green, r_blue;
    logic        r_trailer, r_end_row, r_hdr_sent;
    logic [pngse_pkg::POS_W-1:0] r_col, r_row;
    logic [15:0] r_blk;
    logic [pngse_pkg::RAW_W-1:0] r_raw_left;
    logic [31:0] r_zlen;
    pngse_pkg::t_acc r_acc;
    logic        r_ov;
    logic [7:0]  r_ob;
    logic        r_olast, r_oeof;

    pngse_pkg::t_acc n_acc;
    logic [12:0] w_side, h_side;
    logic        in_ready, accept, active, emit;
    logic [7:0]  byte_v;
    logic        crc_en, raw_en, fin, phase_end;
    logic [2:0]  plen;
    t_phase      nxt, n_phase;
    logic [15:0] blk_n;
    logic        blk_final;
    logic [27:0] prod;
    logic [26:0] zy;
    logic [16:0] zs;
    logic [11:0] zblocks;
    logic [12:0] col_nx, row_nx;

    // clamp sizes to 1..MAX_SIDE
    always_comb begin
        w_side = (r_width == '0) ? 13'd1
               : (r_width > 13'(pngse_pkg::MAX_SIDE)) ? 13'(pngse_pkg::MAX_SIDE) : r_width;
        h_side = (r_height == '0) ? 13'd1
               : (r_height > 13'(pngse_pkg::MAX_SIDE)) ? 13'(pngse_pkg::MAX_SIDE) : r_height;
        prod   = ({2'd0, w_side} * 15'd3 + 15'd1) * {2'd0, h_side};
        col_nx = {1'b0, r_col} + 13'd1;
        row_nx = {1'b0, r_row} + 13'd1;
    end

    // idat length: 6 + 5 * ceil(raw / 65535) + raw
    always_comb begin
        zy      = {1'b0, r_raw_left} + 27'd65534;
        zs      = {6'd0, zy[26:16]} + {1'b0, zy[15:0]};
        zblocks = {1'b0, zy[26:16]} + ((zs >= 17'd65535) ? 12'd1 : 12'd0);
    end

    // stored block header values
    always_comb begin
        blk_final = (r_raw_left <= pngse_pkg::RAW_W'(pngse_pkg::BLOCK_MAX));
        blk_n     = blk_final ? r_raw_left[15:0] : pngse_pkg::BLOCK_MAX;
    end

    assign in_ready    = (r_phase == P_IDLE) || (r_phase == P_HOLD);
    assign i_pix.ready = in_ready;
    assign accept      = i_pix.valid && in_ready;
    assign active      = !in_ready;
    assign emit        = active && (!r_ov || o_res.ready);

    // byte selection for the current phase
    always_comb begin
        byte_v = '0;
        crc_en = 1'b0;
        raw_en = 1'b0;
        fin    = 1'b0;
        plen   = 3'd3;
        nxt    = r_phase;
        case (r_phase)
            P_SIG: begin
                byte_v = pngse_pkg::sig_byte(r_idx);
                plen   = 3'd7;
                nxt    = P_IHLEN;
            end
            P_IHLEN: begin
                byte_v = pngse_pkg::be_byte(32'd13, r_idx[1:0]);
                nxt    = P_IHTAG;
            end
            P_IHTAG: begin
                byte_v = pngse_pkg::be_byte(pngse_pkg::TAG_IHDR, r_idx[1:0]);
                crc_en = 1'b1;
                nxt    = P_IHW;
            end
            P_IHW: begin
                byte_v = pngse_pkg::be_byte({19'd0, w_side}, r_idx[1:0]);
                crc_en = 1'b1;
                nxt    = P_IHH;
            end
            P_IHH: begin
                byte_v = pngse_pkg::be_byte({19'd0, h_side}, r_idx[1:0]);
                crc_en = 1'b1;
                nxt    = P_IHMISC;
            end
            P_IHMISC: begin
                // bit depth 8, color type 2, then three zero bytes
                byte_v = (r_idx == 3'd0) ? 8'd8 : (r_idx == 3'd1) ? 8'd2 : 8'd0;
                crc_en = 1'b1;
                plen   = 3'd4;
                nxt    = P_IHCRC;
            end
            P_IHCRC: begin
                byte_v = pngse_pkg::be_byte(~r_acc.crc, r_idx[1:0]);
                nxt    = P_ZLEN;
            end
            P_ZLEN: begin
                byte_v = pngse_pkg::be_byte(r_zlen, r_idx[1:0]);
                nxt    = P_IDTAG;
            end
            P_IDTAG: begin
                byte_v = pngse_pkg::be_byte(pngse_pkg::TAG_IDAT, r_idx[1:0]);
                crc_en = 1'b1;
                nxt    = P_ZHDR;
            end
            P_ZHDR: begin
                byte_v = (r_idx == 3'd0) ? pngse_pkg::ZLIB_CMF : pngse_pkg::ZLIB_FLG;
                crc_en = 1'b1;
                plen   = 3'd1;
                nxt    = (r_blk == '0) ? P_BHDR : P_RAW;
            end
            P_BHDR: begin
                case (r_idx)
                    3'd0:    byte_v = {7'd0, blk_final};
                    3'd1:    byte_v = blk_n[7:0];
                    3'd2:    byte_v = blk_n[15:8];
                    3'd3:    byte_v = ~blk_n[7:0];
                    default: byte_v = ~blk_n[15:8];
                endcase
                crc_en = 1'b1;
                plen   = 3'd4;
                nxt    = P_RAW;
            end
            P_RAW: begin
                case (r_ridx)
                    2'd0:    byte_v = 8'd0;
                    2'd1:    byte_v = r_red;
                    2'd2:    byte_v = r_green;
                    default: byte_v = r_blue;
                endcase
                crc_en = 1'b1;
                raw_en = 1'b1;
                plen   = 3'd0;
                if (r_ridx == 2'd3) begin
                    fin = !r_trailer;
                    nxt = r_trailer ? P_ADL : P_IDLE;
                end else begin
                    nxt = (r_blk == 16'd1) ? P_BHDR : P_RAW;
                end
            end
            P_ADL: begin
                byte_v = pngse_pkg::be_byte({r_acc.adl_hi, r_acc.adl_lo}, r_idx[1:0]);
                crc_en = 1'b1;
                nxt    = P_IDCRC;
            end
            P_IDCRC: begin
                byte_v = pngse_pkg::be_byte(~r_acc.crc, r_idx[1:0]);
                nxt    = P_IELEN;
            end
            P_IELEN: begin
                byte_v = 8'd0;
                nxt    = P_IETAG;
            end
            P_IETAG: begin
                byte_v = pngse_pkg::be_byte(pngse_pkg::TAG_IEND, r_idx[1:0]);
                crc_en = 1'b1;
                nxt    = P_IECRC;
            end
            P_IECRC: begin
                byte_v = pngse_pkg::be_byte(~r_acc.crc, r_idx[1:0]);
                fin    = (r_idx == 3'd3);
                nxt    = P_IDLE;
            end
            default: begin
                nxt = r_phase;
            end
        endcase
        phase_end = (r_idx == plen);
        n_phase   = phase_end ? nxt : r_phase;
    end

    pngse_acc u_acc (
        .i_crc_en (crc_en),
        .i_raw_en (raw_en),
        .i_byte   (byte_v),
        .i_acc    (r_acc),
        .o_acc    (n_acc)
    );

    // sequencer, checksums and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= P_IDLE;
            r_resume   <= P_IDLE;
            r_idx      <= '0;
            r_ridx     <= '0;
            r_cnt      <= '0;
            r_width    <= 13'd1280;
            r_height   <= 13'd720;
            r_trailer  <= 1'b0;
            r_end_row  <= 1'b0;
            r_hdr_sent <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_blk      <= '0;
            r_raw_left <= '0;
            r_acc      <= '{crc: pngse_pkg::CRC_SEED, adl_lo: 16'd1, adl_hi: 16'd0};
            r_ov       <= 1'b0;
        end else begin
            r_zlen <= 32'd6 + {20'd0, zblocks} * 32'd5 + {6'd0, r_raw_left};
            if (o_res.ready && (i_cfg_we || !emit)) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                // any register write drops the file in progress
                if (i_cfg_idx == pngse_pkg::REG_WIDTH) r_width <= i_cfg_data;
                if (i_cfg_idx == pngse_pkg::REG_HEIGHT) r_height <= i_cfg_data;
                r_phase    <= P_IDLE;
                r_hdr_sent <= 1'b0;
                r_col      <= '0;
                r_row      <= '0;
                r_blk      <= '0;
                r_raw_left <= '0;
                r_acc      <= '{crc: pngse_pkg::CRC_SEED, adl_lo: 16'd1, adl_hi: 16'd0};
            end else if (accept && r_phase == P_HOLD) begin
                // held bytes resume, pixel dropped
                r_phase <= r_resume;
                r_cnt   <= '0;
            end else if (accept) begin
                r_red     <= i_pix.red;
                r_green   <= i_pix.green;
                r_blue    <= i_pix.blue;
                r_end_row <= (col_nx >= w_side);
                r_trailer <= (col_nx >= w_side) && (row_nx >= h_side);
                r_ridx    <= (r_col == '0) ? 2'd0 : 2'd1;
                r_idx     <= '0;
                r_cnt     <= '0;
                if (!r_hdr_sent) begin
                    r_hdr_sent <= 1'b1;
                    r_raw_left <= prod[pngse_pkg::RAW_W-1:0];
                    r_blk      <= '0;
                    r_phase    <= P_SIG;
                end else begin
                    r_phase <= (r_blk == '0) ? P_BHDR : P_RAW;
                end
            end else if (emit) begin
                r_ov    <= 1'b1;
                r_ob    <= byte_v;
                r_olast <= fin || (r_cnt == pngse_pkg::CNT_W'(pngse_pkg::RUN_MAX - 1));
                r_oeof  <= fin && (r_phase == P_IECRC);
                r_idx   <= phase_end ? 3'd0 : r_idx + 3'd1;
                if (raw_en) begin
                    r_blk      <= r_blk - 16'd1;
                    r_raw_left <= r_raw_left - pngse_pkg::RAW_W'(1);
                    r_ridx     <= r_ridx + 2'd1;
                end
                if (r_phase == P_BHDR && phase_end) begin
                    r_blk <= blk_n;
                end
                if (r_phase == P_RAW && r_ridx == 2'd3) begin
                    r_col <= r_end_row ? '0 : col_nx[pngse_pkg::POS_W-1:0];
                    if (r_end_row) r_row <= row_nx[pngse_pkg::POS_W-1:0];
                end
                // checksum update, crc restarts after each chunk
                if (r_phase == P_IECRC && phase_end) begin
                    r_acc <= '{crc: pngse_pkg::CRC_SEED, adl_lo: 16'd1, adl_hi: 16'd0};
                end else if (phase_end && (r_phase == P_IHCRC || r_phase == P_IDCRC)) begin
                    r_acc <= '{crc: pngse_pkg::CRC_SEED, adl_lo: n_acc.adl_lo,
                               adl_hi: n_acc.adl_hi};
                end else begin
                    r_acc <= n_acc;
                end
                if (r_phase == P_IECRC && phase_end) begin
                    r_hdr_sent <= 1'b0;
                    r_col      <= '0;
                    r_row      <= '0;
                    r_blk      <= '0;
                    r_raw_left <= '0;
                end
                if (!fin && r_cnt == pngse_pkg::CNT_W'(pngse_pkg::RUN_MAX - 1)) begin
                    r_phase  <= P_HOLD;
                    r_resume <= n_phase;
                end else begin
                    r_phase <= n_phase;
                    r_cnt   <= r_cnt + pngse_pkg::CNT_W'(1);
                end
            end
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.out_byte    = r_ob;
    assign o_res.last_of_run = r_olast;
    assign o_res.end_of_file = r_oeof;

    // a run never goes past its byte budget
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= pngse_pkg::CNT_W'(pngse_pkg::RUN_MAX))
        else $error("run byte count out of range");

    // the last byte of the file leaves no raw byte pending
    a_raw_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_phase == P_IECRC && phase_end) |-> (r_raw_left == '0))
        else $error("raw bytes left at end of file");

    // after the file ends the next pixel starts a new header
    a_hdr_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !i_cfg_we && r_phase == P_IECRC && phase_end) |=> !r_hdr_sent)
        else $error("header flag not cleared after file end");

    // a stored block header is only sent while raw bytes remain
    a_blk_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_phase == P_BHDR) |-> (r_raw_left != '0))
        else $error("block header with no raw bytes left");
endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench of png_stored_image_encoder_unit, pixels in, file bytes out
// depends on pngse_pkg, pngse_pix_if, pngse_byte_if and the rtl of the encoder
module testbench;

    localparam int LIMIT     = 600000;
    localparam int LONG_HOLD = 400;
    localparam int SETTLE    = 80;

    typedef struct {
        logic [7:0] b;
        logic       last;
        logic       eof;
    } t_file_beat;

    // predicts the file bytes each accepted pixel causes
    class png_file_model;
        int unsigned width_reg, height_reg;
        logic [31:0] crc;
        int unsigned adl_lo, adl_hi, col, row, blk_left, raw_left;
        bit          header_done;
        logic [7:0]  run_q[$];
        logic [7:0]  held_q[$];
        int          eof_at;
        t_file_beat  file_q[$];

        function new();
            width_reg  = 1280;
            height_reg = 720;
            restart();
        endfunction

        function void restart();
            crc = pngse_pkg::CRC_SEED;
            adl_lo = 1;
            adl_hi = 0;
            col = 0;
            row = 0;
            blk_left = 0;
            raw_left = 0;
            header_done = 0;
            held_q.delete();
        endfunction

        function void set_reg(logic [0:0] idx, logic [12:0] v);
            if (idx == pngse_pkg::REG_WIDTH) width_reg = v;
            else height_reg = v;
            restart();
        endfunction

        function int unsigned side(int unsigned v);
            if (v < 1) return 1;
            if (v > pngse_pkg::MAX_SIDE) return pngse_pkg::MAX_SIDE;
            return v;
        endfunction

        function void emit(logic [7:0] b, bit with_crc);
            logic [31:0] c;
            if (with_crc) begin
                c = crc ^ {24'd0, b};
                for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
                crc = c;
            end
            run_q.push_back(b);
        endfunction

        function void emit32(logic [31:0] v, bit with_crc);
            for (int s = 24; s >= 0; s -= 8) emit(v[s +: 8], with_crc);
        endfunction

        function void emit_crc();
            emit32(crc ^ 32'hFFFFFFFF, 0);
            crc = pngse_pkg::CRC_SEED;
        endfunction

        // raw byte of the zlib stream, opening a stored block when needed
        function void emit_raw(logic [7:0] b);
            int unsigned n;
            if (blk_left == 0) begin
                n = raw_left > 65535 ? 65535 : raw_left;
                emit(raw_left <= 65535 ? 8'd1 : 8'd0, 1);
                emit(n[7:0], 1);
                emit(n[15:8], 1);
                emit(~n[7:0], 1);
                emit(~n[15:8], 1);
                blk_left = n;
            end
            emit(b, 1);
            adl_lo = (adl_lo + b) % 65521;
            adl_hi = (adl_hi + adl_lo) % 65521;
            if (blk_left > 0) blk_left--;
            if (raw_left > 0) raw_left--;
        endfunction

        function void emit_header(int unsigned w, int unsigned h);
            int unsigned raw_len, blocks;
            raw_len = (w * 3 + 1) * h;
            blocks = (raw_len + 65534) / 65535;
            emit32(32'h89504E47, 0);
            emit32(32'h0D0A1A0A, 0);
            emit32(32'd13, 0);
            crc = pngse_pkg::CRC_SEED;
            emit32(pngse_pkg::TAG_IHDR, 1);
            emit32(w, 1);
            emit32(h, 1);
            emit(8'd8, 1); emit(8'd2, 1); emit(8'd0, 1); emit(8'd0, 1); emit(8'd0, 1);
            emit_crc();
            emit32(2 + blocks * 5 + raw_len + 4, 0);
            emit32(pngse_pkg::TAG_IDAT, 1);
            emit(pngse_pkg::ZLIB_CMF, 1);
            emit(pngse_pkg::ZLIB_FLG, 1);
            raw_left = raw_len;
            blk_left = 0;
            adl_lo = 1;
            adl_hi = 0;
            header_done = 1;
        endfunction

        function void emit_trailer();
            emit32({adl_hi[15:0], adl_lo[15:0]}, 1);
            emit_crc();
            emit32(32'd0, 0);
            emit32(pngse_pkg::TAG_IEND, 1);
            emit_crc();
            eof_at = run_q.size() - 1;
            restart();
        endfunction

        // one accepted pixel beat
        function void add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] bl);
            int unsigned w, h;
            int n, held_n;
            w = side(width_reg);
            h = side(height_reg);
            // leftover bytes of an overlong run go out instead, pixel dropped
            if (held_q.size() > 0) begin
                held_n = held_q.size();
                n = held_n > pngse_pkg::RUN_MAX ? pngse_pkg::RUN_MAX : held_n;
                for (int k = 0; k < n; k++)
                    file_q.push_back('{held_q.pop_front(), k == n - 1, k == n - 1 && n == held_n});
                return;
            end
            run_q.delete();
            eof_at = -1;
            if (!header_done) emit_header(w, h);
            if (col == 0) emit_raw(8'd0);
            emit_raw(r);
            emit_raw(g);
            emit_raw(bl);
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) emit_trailer();
            end
            n = run_q.size() > pngse_pkg::RUN_MAX ? pngse_pkg::RUN_MAX : run_q.size();
            for (int k = 0; k < run_q.size(); k++) begin
                if (k < n) file_q.push_back('{run_q[k], k == n - 1, k == eof_at});
                else held_q.push_back(run_q[k]);
            end
        endfunction

        // compares one output beat with the oldest expected byte
        function string check_beat(logic [7:0] b, logic l, logic e);
            t_file_beat x;
            if (file_q.size() == 0) return $sformatf("unexpected byte %02h", b);
            x = file_q.pop_front();
            if (b !== x.b || l !== x.last || e !== x.eof)
                return $sformatf("byte %02h last %b eof %b, wanted %02h %b %b",
                                 b, l, e, x.b, x.last, x.eof);
            return "";
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_idx;
    logic [12:0] cfg_data;

    pngse_pix_if  pix ();
    pngse_byte_if res ();

    png_file_model model;
    int  errors;
    int  cycles;
    int  pixels_sent;
    bit  rx_idle_on;
    bit  rx_hold_req;

    png_stored_image_encoder_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix),
        .o_res      (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // byte receiver with random stalls and an on-demand long hold
    initial begin
        int gap;
        string msg;
        res.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                res.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                rx_hold_req = 0;
            end
            gap = rx_idle_on ? $urandom_range(0, 13) : 0;
            if (gap > 0) begin
                res.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res.ready = 1'b1;
            @(posedge i_clk);
            while (res.valid !== 1'b1) @(posedge i_clk);
            msg = model.check_beat(res.out_byte, res.last_of_run, res.end_of_file);
            if (msg != "") report(msg);
        end
    end

    // wait until every expected byte is out, then let the block settle
    task automatic drain();
        while (model.file_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [12:0] v);
        @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = v;
        @(negedge i_clk);
        cfg_we = 1'b0;
        model.set_reg(idx, v);
    endtask

    // one pixel beat; gaps drawn per pixel when enabled
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            pix.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix.valid = 1'b1;
        pix.red = r;
        pix.green = g;
        pix.blue = b;
        @(posedge i_clk);
        while (pix.ready !== 1'b1) @(posedge i_clk);
        model.add_pixel(r, g, b);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count, input bit gaps);
        for (int k = 0; k < count; k++)
            send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), gaps);
        pix.valid = 1'b0;
    endtask

    initial begin
        int w, h, count;
        model = new();
        errors = 0;
        cycles = 0;
        pixels_sent = 0;
        rx_idle_on = 1;
        rx_hold_req = 0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = pngse_pkg::REG_WIDTH;
        cfg_data = '0;
        pix.valid = 1'b0;
        pix.red = '0;
        pix.green = '0;
        pix.blue = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // default size, color extremes, header on the first pixel
        send_pixel(8'd0, 8'd0, 8'd0, 1);
        send_pixel(8'd255, 8'd255, 8'd255, 1);
        send_pixel(8'hAA, 8'h55, 8'h0F, 0);
        send_pixel(8'h55, 8'hAA, 8'hF0, 0);
        pix.valid = 1'b0;
        drain();

        // zero sizes read as one: one-pixel files with a held-over tail
        write_reg(pngse_pkg::REG_WIDTH, 13'd0);
        write_reg(pngse_pkg::REG_HEIGHT, 13'd0);
        send_pixel(8'd1, 8'd128, 8'd254, 1);
        send_pixel(8'd7, 8'd7, 8'd7, 0);
        send_pixel(8'd200, 8'd100, 8'd50, 0);
        send_pixel(8'd9, 8'd9, 8'd9, 1);
        pix.valid = 1'b0;
        drain();

        // oversize reads as the maximum side, file abandoned later
        write_reg(pngse_pkg::REG_WIDTH, 13'h1FFF);
        write_reg(pngse_pkg::REG_HEIGHT, 13'h1FFF);
        send_random(3, 1);
        drain();
        write_reg(pngse_pkg::REG_WIDTH, 13'd4096);
        write_reg(pngse_pkg::REG_HEIGHT, 13'd4097);
        send_random(2, 1);
        drain();

        // 3x2 file and the start of the next one; receiver held off long,
        // sender pausing until all output is in
        write_reg(pngse_pkg::REG_WIDTH, 13'd3);
        write_reg(pngse_pkg::REG_HEIGHT, 13'd2);
        rx_hold_req = 1;
        send_random(4, 0);
        while (model.file_q.size() != 0) @(negedge i_clk);
        send_random(4, 1);
        drain();

        // random sizes, mostly whole files
        while (pixels_sent < 130) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 6);
            h = $urandom_range(1, 4);
            if ($urandom_range(0, 2) != 0) write_reg(pngse_pkg::REG_WIDTH, 13'(w));
            write_reg(pngse_pkg::REG_HEIGHT, 13'(h));
            rx_idle_on = $urandom_range(0, 3) != 0;
            w = model.side(model.width_reg);
            h = model.side(model.height_reg);
            if (w * h <= 24 && $urandom_range(0, 3) != 0) count = w * h + $urandom_range(0, 2);
            else count = $urandom_range(1, 12);
            send_random(count, $urandom_range(0, 3) != 0);
            drain();
        end

        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
